// ===== rtl/core/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indices and limits for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// Field widths
	localparam int DATA_W = 32;
	localparam int PER_W  = 16;
	localparam int IDX_W  = 3;

	// Configuration register indices
	typedef enum logic [IDX_W-1:0] {
		REG_KP      = 3'd0,
		REG_KI      = 3'd1,
		REG_KD      = 3'd2,
		REG_TARGET  = 3'd3,
		REG_PERIOD  = 3'd4,
		REG_OUT_MIN = 3'd5,
		REG_OUT_MAX = 3'd6
	} cfg_reg_t;

	// Saturation limits of a 32-bit signed value
	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	// Reset value of the period register
	localparam logic [PER_W-1:0] PERIOD_RST = 16'd1;

endpackage

// ===== rtl/core/pidc_if.sv =====
// ----------------------------------------------------------------------------
// pidc_if
// Valid/ready channels of the PID controller: samples, actions, config writes.
// ----------------------------------------------------------------------------

// Measured sample channel
interface pidc_in_if;
	import pidc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measured;
	modport source (output valid, output measured, input ready);
	modport sink   (input valid, input measured, output ready);
endinterface

// Control action channel
interface pidc_out_if;
	import pidc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

// Configuration write channel
interface pidc_cfg_if;
	import pidc_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pid_controller_with_clamp_core.sv =====
// ----------------------------------------------------------------------------
// pid_controller_with_clamp_core
// Fixed-point PID controller with output saturation and integral anti-windup.
// ----------------------------------------------------------------------------
// One measured sample in, one saturated control action out. An accepted
// sample passes through S_ERR, S_PREP, S_MUL1, S_MID, S_MUL2 and S_ACC to
// S_SUM, where its action is written to the output register once it is free.
// Two passes of 32 bit-serial steps do the work: the first runs the proportional
// and integral products together with the 32-step restoring divider for the
// derivative, the second runs the derivative product and the 16-step scaling
// of the integral increment by the period. One sample is in work at a time;
// a finished action may wait in the output register while the next sample is
// accepted. Configuration writes are taken in every cycle and should only be
// made while the block is idle. Indices beyond the last register are ignored.
// ----------------------------------------------------------------------------
module pid_controller_with_clamp_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pidc_cfg_if.sink      cfg,
	pidc_in_if.sink       sample,
	pidc_out_if.source    action
);
	import pidc_pkg::*;

	// Gain product after the fractional shift, period product, final sum
	localparam int GW = 2 * DATA_W - FRAC_BITS;
	localparam int XW = GW + PER_W;
	localparam int SW = GW + 2;

	typedef enum logic [2:0] {
		S_IDLE, S_ERR, S_PREP, S_MUL1, S_MID, S_MUL2, S_ACC, S_SUM
	} state_t;

	state_t state_q;

	// Configuration registers
	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, target_q, out_min_q, out_max_q;
	logic [PER_W-1:0]         period_q;

	// Controller state
	logic signed [DATA_W-1:0] integral_q;
	logic signed [DATA_W-1:0] prev_err_q;

	// Sequencing and output
	logic [4:0]               cnt_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;

	// Datapath registers
	logic signed [DATA_W-1:0] meas_q;
	logic signed [DATA_W-1:0] err_q;
	logic [PER_W-1:0]         per_q;
	logic [2*DATA_W-1:0]      prod_p_q, prod_i_q, prod_d_q;
	logic [XW-1:0]            prod_x_q;
	logic [DATA_W-1:0]        dq_q;
	logic [PER_W-1:0]         rem_q;
	logic                     neg_q;

	// One step of the signed shift-add multiplier, multiplier bits LSB first
	function automatic logic [2*DATA_W-1:0] mul_step(
		input logic [2*DATA_W-1:0]     acc,
		input logic signed [DATA_W-1:0] mcand,
		input logic                     last
	);
		logic signed [DATA_W:0] hi;
		logic signed [DATA_W:0] ad;
		hi = $signed({acc[2*DATA_W-1], acc[2*DATA_W-1:DATA_W]});
		ad = $signed({mcand[DATA_W-1], mcand});
		if (acc[0]) begin
			if (last) hi = hi - ad;
			else hi = hi + ad;
		end
		return {hi, acc[DATA_W-1:1]};
	endfunction

	// Error against setpoint, saturated
	logic signed [DATA_W:0]   err_wide;
	logic signed [DATA_W-1:0] err_sat;
	always_comb begin
		err_wide = $signed({target_q[DATA_W-1], target_q}) - $signed({meas_q[DATA_W-1], meas_q});
		if (err_wide[DATA_W] != err_wide[DATA_W-1])
			err_sat = err_wide[DATA_W] ? SAT_MIN : SAT_MAX;
		else
			err_sat = err_wide[DATA_W-1:0];
	end

	// Error difference for the derivative, as sign and magnitude
	logic signed [DATA_W:0] diff;
	logic [DATA_W:0]        diff_mag;
	always_comb begin
		diff     = $signed({err_q[DATA_W-1], err_q}) - $signed({prev_err_q[DATA_W-1], prev_err_q});
		diff_mag = diff[DATA_W] ? (~diff + 1'b1) : diff;
	end

	// Restoring divider step
	logic [PER_W:0]   div_r2;
	logic             div_ge;
	logic [PER_W:0]   div_sub;
	logic [PER_W-1:0] rem_nxt;
	always_comb begin
		div_r2  = {rem_q, dq_q[DATA_W-1]};
		div_ge  = div_r2 >= {1'b0, per_q};
		div_sub = div_r2 - {1'b0, per_q};
		rem_nxt = div_ge ? div_sub[PER_W-1:0] : div_r2[PER_W-1:0];
	end

	// Signed, saturated quotient
	logic [DATA_W:0]          quo_s;
	logic signed [DATA_W-1:0] deriv;
	always_comb begin
		quo_s = neg_q ? (~{1'b0, dq_q} + 1'b1) : {1'b0, dq_q};
		if (quo_s[DATA_W] != quo_s[DATA_W-1])
			deriv = quo_s[DATA_W] ? SAT_MIN : SAT_MAX;
		else
			deriv = quo_s[DATA_W-1:0];
	end

	// Integral product times period, one period bit per step
	logic [GW-1:0] t1;
	logic [GW:0]   x_hi;
	always_comb begin
		t1   = prod_i_q[2*DATA_W-1:FRAC_BITS];
		x_hi = {prod_x_q[XW-1], prod_x_q[XW-1:PER_W]};
		if (prod_x_q[0]) x_hi = x_hi + {t1[GW-1], t1};
	end

	// Halved increment and new integral term, both saturated
	logic [XW-2:0]            inc_wide;
	logic signed [DATA_W-1:0] inc;
	logic signed [DATA_W:0]   int_wide;
	logic signed [DATA_W-1:0] int_new;
	always_comb begin
		inc_wide = prod_x_q[XW-1:1];
		if ((&inc_wide[XW-2:DATA_W-1]) || !(|inc_wide[XW-2:DATA_W-1]))
			inc = inc_wide[DATA_W-1:0];
		else
			inc = inc_wide[XW-2] ? SAT_MIN : SAT_MAX;
		int_wide = $signed({integral_q[DATA_W-1], integral_q}) + $signed({inc[DATA_W-1], inc});
		if (int_wide[DATA_W] != int_wide[DATA_W-1])
			int_new = int_wide[DATA_W] ? SAT_MIN : SAT_MAX;
		else
			int_new = int_wide[DATA_W-1:0];
	end

	// P + I + D, output limits and integral clamp
	logic [GW-1:0]            p_term, d_term;
	logic signed [SW-1:0]     sum, max_ext, min_ext;
	logic signed [DATA_W-1:0] drive_nxt, int_clamp;
	always_comb begin
		p_term  = prod_p_q[2*DATA_W-1:FRAC_BITS];
		d_term  = prod_d_q[2*DATA_W-1:FRAC_BITS];
		max_ext = $signed({{(SW-DATA_W){out_max_q[DATA_W-1]}}, out_max_q});
		min_ext = $signed({{(SW-DATA_W){out_min_q[DATA_W-1]}}, out_min_q});
		sum     = $signed({{2{p_term[GW-1]}}, p_term})
		        + $signed({{2{d_term[GW-1]}}, d_term})
		        + $signed({{(SW-DATA_W){integral_q[DATA_W-1]}}, integral_q});
		if (sum > max_ext)      drive_nxt = out_max_q;
		else if (sum < min_ext) drive_nxt = out_min_q;
		else                    drive_nxt = sum[DATA_W-1:0];
		int_clamp = integral_q;
		if (int_clamp > out_max_q) int_clamp = out_max_q;
		if (int_clamp < out_min_q) int_clamp = out_min_q;
	end

	// Handshakes
	assign sample.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign action.valid = out_valid_q;
	assign action.drive = drive_q;

	logic out_free;
	assign out_free = !out_valid_q || action.ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= '0;
			ki_q      <= '0;
			kd_q      <= '0;
			target_q  <= '0;
			period_q  <= PERIOD_RST;
			out_min_q <= SAT_MIN;
			out_max_q <= SAT_MAX;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_KP:      kp_q      <= cfg.data;
				REG_KI:      ki_q      <= cfg.data;
				REG_KD:      kd_q      <= cfg.data;
				REG_TARGET:  target_q  <= cfg.data;
				REG_PERIOD:  period_q  <= cfg.data[PER_W-1:0];
				REG_OUT_MIN: out_min_q <= cfg.data;
				REG_OUT_MAX: out_max_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			integral_q  <= '0;
			prev_err_q  <= '0;
		end else begin
			// a new action replaces the one leaving in the same cycle
			if (state_q == S_SUM && out_free) out_valid_q <= 1'b1;
			else if (action.ready)            out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) state_q <= S_ERR;
				end
				S_ERR: state_q <= S_PREP;
				S_PREP: begin
					prev_err_q <= err_q;
					cnt_q      <= '0;
					state_q    <= S_MUL1;
				end
				S_MUL1: begin
					cnt_q <= cnt_q + 5'd1;
					if (&cnt_q) state_q <= S_MID;
				end
				S_MID: begin
					cnt_q   <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q + 5'd1;
					if (&cnt_q) state_q <= S_ACC;
				end
				S_ACC: begin
					integral_q <= int_new;
					state_q    <= S_SUM;
				end
				S_SUM: begin
					if (out_free) begin
						drive_q     <= drive_nxt;
						integral_q  <= int_clamp;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (sample.valid) meas_q <= sample.measured;
			end
			S_ERR: err_q <= err_sat;
			S_PREP: begin
				neg_q    <= diff[DATA_W];
				dq_q     <= diff_mag[DATA_W-1:0];
				rem_q    <= '0;
				per_q    <= (period_q == '0) ? PERIOD_RST : period_q;
				prod_p_q <= {{DATA_W{1'b0}}, err_q};
				prod_i_q <= {{DATA_W{1'b0}}, err_q};
			end
			S_MUL1: begin
				prod_p_q <= mul_step(prod_p_q, kp_q, &cnt_q);
				prod_i_q <= mul_step(prod_i_q, ki_q, &cnt_q);
				rem_q    <= rem_nxt;
				dq_q     <= {dq_q[DATA_W-2:0], div_ge};
			end
			S_MID: begin
				prod_d_q <= {{DATA_W{1'b0}}, deriv};
				prod_x_q <= {{GW{1'b0}}, per_q};
			end
			S_MUL2: begin
				prod_d_q <= mul_step(prod_d_q, kd_q, &cnt_q);
				if (!cnt_q[4]) prod_x_q <= {x_hi, prod_x_q[PER_W-1:1]};
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/pid_controller_with_clamp_core_tb.sv =====
// ----------------------------------------------------------------------------
// pid_controller_with_clamp_core_tb
// Self-checking bench for the clamped fixed-point PID controller.
// Measured samples go in on a valid/ready channel. A cycle-free predictor keeps
// its own integral term, last error and register copies, and works out each
// control action when its sample is accepted. Every action that leaves the block
// is checked against the oldest prediction. Register settings change only while
// the block is idle. A directed pass covers field extremes, a zero period,
// crossed limits, a mid-run integral gain change and a spare register index.
// Random phases follow with back-pressure and random gaps on both channels.
// ----------------------------------------------------------------------------
module pid_controller_with_clamp_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pidc_pkg::*;

	localparam int FRAC = 16;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;           // index with no register
	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

	logic clk;
	logic arst_n;

	pidc_cfg_if cfg_ch();
	pidc_in_if  sample_ch();
	pidc_out_if action_ch();

	pid_controller_with_clamp_core #(.FRAC_BITS(FRAC)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.action (action_ch)
	);

	// Register copies and controller state of the predictor
	logic signed [DATA_W-1:0] mir_kp     = '0;
	logic signed [DATA_W-1:0] mir_ki     = '0;
	logic signed [DATA_W-1:0] mir_kd     = '0;
	logic signed [DATA_W-1:0] mir_target = '0;
	logic        [PER_W-1:0]  mir_period = PERIOD_RST;
	logic signed [DATA_W-1:0] mir_min    = SAT_MIN;
	logic signed [DATA_W-1:0] mir_max    = SAT_MAX;
	longint integ_acc  = 0;
	longint last_error = 0;

	logic signed [DATA_W-1:0] drive_expected[$];
	logic signed [DATA_W-1:0] drive_want;

	int err_count      = 0;
	int samples_sent   = 0;
	int drives_checked = 0;
	int reg_writes     = 0;
	int settings_used  = 0;
	int rx_hold_req    = 0;
	bit tx_idle_on     = 1'b1;
	bit rx_idle_on     = 1'b1;

	// Clock, 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// Q16.16 gain times value, floor of the scaled product
	function automatic longint mul_q(input longint g, input longint v);
		return (g * v) >>> FRAC;
	endfunction

	// One controller step: updates integral and last error, returns the action
	function automatic logic signed [DATA_W-1:0] step_controller(
			input logic signed [DATA_W-1:0] meas);
		longint per;
		longint err;
		longint inc;
		longint deriv;
		longint sum;
		per = (mir_period == '0) ? 64'sd1 : longint'(mir_period);
		err = clamp32(longint'(mir_target) - longint'(meas));

		inc       = clamp32((mul_q(longint'(mir_ki), err) * per) >>> 1);
		integ_acc = clamp32(integ_acc + inc);

		deriv      = clamp32((err - last_error) / per);
		last_error = err;

		sum = mul_q(longint'(mir_kp), err) + integ_acc + mul_q(longint'(mir_kd), deriv);
		// upper limit wins the test order when limits are crossed
		if (sum > longint'(mir_max))
			sum = longint'(mir_max);
		else if (sum < longint'(mir_min))
			sum = longint'(mir_min);

		// anti-windup on the stored term
		if (integ_acc > longint'(mir_max))
			integ_acc = longint'(mir_max);
		if (integ_acc < longint'(mir_min))
			integ_acc = longint'(mir_min);
		return sum[DATA_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		if (r < 98)
			return $urandom_range(5, 30);
		return $urandom_range(50, 150);
	endfunction

	function automatic int rand_signed(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return ($urandom_range(0, 1) != 0) ? SAT_MAX : SAT_MIN;
			2: return '0;
			default: return rand_signed(32'h0004_0000);
		endcase
	endfunction

	function automatic logic [PER_W-1:0] rand_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 16'hFFFF;
			2: return PER_W'($urandom_range(0, 65535));
			default: return PER_W'($urandom_range(1, 20));
		endcase
	endfunction

	// Sample near the setpoint, a small step from the last one, or anything
	function automatic logic signed [DATA_W-1:0] rand_sample(
			input logic signed [DATA_W-1:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return DATA_W'(clamp32(longint'(mir_target) + rand_signed(32'h0003_0000)));
		if (r < 85)
			return DATA_W'(clamp32(longint'(prev) + rand_signed(32'h0000_4000)));
		return $urandom;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------
	// Offer one sample; valid is left high so a back-to-back sample follows
	// without a dip. The caller lowers it through drain_actions.
	task automatic send_sample(input logic signed [DATA_W-1:0] meas);
		int gap;
		gap = tx_idle_on ? gap_len() : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.measured <= meas;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		drive_expected.push_back(step_controller(meas));
		samples_sent++;
	endtask

	// Stop offering and wait until every predicted action has arrived
	task automatic drain_actions();
		sample_ch.valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// One register transaction; valid stays high for a following write
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			REG_KP:      mir_kp     = val;
			REG_KI:      mir_ki     = val;
			REG_KD:      mir_kd     = val;
			REG_TARGET:  mir_target = val;
			REG_PERIOD:  mir_period = val[PER_W-1:0];
			REG_OUT_MIN: mir_min    = val;
			REG_OUT_MAX: mir_max    = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_config(
			input logic signed [DATA_W-1:0] kp, input logic signed [DATA_W-1:0] ki,
			input logic signed [DATA_W-1:0] kd, input logic signed [DATA_W-1:0] tgt,
			input logic [PER_W-1:0] per,
			input logic signed [DATA_W-1:0] lo, input logic signed [DATA_W-1:0] hi);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_TARGET, tgt);
		write_reg(REG_PERIOD, {{(DATA_W-PER_W){1'b0}}, per});
		write_reg(REG_OUT_MIN, lo);
		write_reg(REG_OUT_MAX, hi);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// ------------------------------------------------------------------
	// Action receiver: random stalls plus long hold-offs on request
	// ------------------------------------------------------------------
	initial begin : action_receiver
		int stall;
		stall = 0;
		action_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				stall       = rx_hold_req;
				rx_hold_req = 0;
			end else if (stall == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall = gap_len();
			end
			if (stall > 0) begin
				action_ch.ready <= 1'b0;
				stall--;
			end else begin
				action_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Action checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && action_ch.valid && action_ch.ready) begin
			if (drive_expected.size() == 0) begin
				$error("drive: nothing expected, got %0d", action_ch.drive);
				err_count++;
			end else begin
				drive_want = drive_expected.pop_front();
				if (action_ch.drive !== drive_want) begin
					$error("drive: expected %0d, got %0d", drive_want, action_ch.drive);
					err_count++;
				end
			end
			drives_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset settings: all gains zero, so every action is zero
	task automatic test_reset_state();
		send_sample('0);
		send_sample(SAT_MAX);
		send_sample(SAT_MIN);
		drain_actions();
	endtask

	// Extremes of the sample and of every register, including error saturation
	task automatic test_field_extremes();
		set_config(Q_ONE, 32'sh0000_8000, 32'sh0000_4000, '0, 16'd1, SAT_MIN, SAT_MAX);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(SAT_MAX);
		send_sample(SAT_MIN);
		drain_actions();
		set_config(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, 16'hFFFF, SAT_MIN, SAT_MAX);
		send_sample(SAT_MIN);
		send_sample(SAT_MAX);
		drain_actions();
	endtask

	// A period of zero behaves as one
	task automatic test_zero_period();
		set_config(Q_ONE, Q_ONE, Q_ONE, 32'sh0002_0000, '0, 32'shFF00_0000, 32'sh0100_0000);
		send_sample('0);
		send_sample(32'sh0003_0000);
		send_sample(-32'sh0001_0000);
		drain_actions();
	endtask

	// Crossed limits: action to upper if above it, else lower; integral to lower
	task automatic test_crossed_limits();
		set_config(Q_ONE, 32'sh0002_0000, Q_ONE, '0, 16'd3, Q_ONE, -Q_ONE);
		send_sample(32'sh0005_0000);
		send_sample(-32'sh0005_0000);
		send_sample('0);
		drain_actions();
	endtask

	// Changing ki leaves the accumulated term as it is
	task automatic test_gain_change();
		set_config(32'sh0000_8000, 32'sh0001_8000, '0, 32'sh0010_0000, 16'd2,
			SAT_MIN, SAT_MAX);
		send_sample('0);
		send_sample(32'sh0004_0000);
		drain_actions();
		write_reg(REG_KI, -32'sh0000_4000);
		cfg_ch.valid <= 1'b0;
		send_sample(32'sh0008_0000);
		send_sample(32'sh000C_0000);
		drain_actions();
	endtask

	// A write to the spare index changes nothing
	task automatic test_spare_register();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		cfg_ch.valid <= 1'b0;
		send_sample(32'sh0010_0000);
		send_sample(32'sh000F_0000);
		drain_actions();
	endtask

	// Long receiver hold-off while samples keep coming, then a full pause and four gapped samples
	task automatic test_backpressure();
		logic signed [DATA_W-1:0] meas;
		meas       = mir_target;
		tx_idle_on = 1'b0;
		rx_hold_req = 400;
		repeat (12) begin
			meas = rand_sample(meas);
			send_sample(meas);
		end
		drain_actions();
		tx_idle_on = 1'b1;
		repeat (4) begin
			meas = rand_sample(meas);
			send_sample(meas);
		end
		drain_actions();
	endtask

	// Random settings per phase, random samples within each
	task automatic test_random_phases();
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] meas;
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = SAT_MIN;
					hi = SAT_MAX;
				end
				1: begin
					lo = rand_signed(32'h0004_0000);
					hi = lo - int'($urandom_range(1, 32'h0004_0000));
				end
				default: begin
					lo = -int'($urandom_range(0, 32'h0100_0000));
					hi =  int'($urandom_range(0, 32'h0100_0000));
				end
			endcase
			if (phase == 9)
				set_config(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN, 16'hFFFF, SAT_MIN, SAT_MAX);
			else if (phase == 8)
				set_config($urandom, $urandom, $urandom, $urandom, PER_W'($urandom), $urandom,
					$urandom);
			else
				set_config(rand_gain(), rand_gain(), rand_gain(), rand_signed(32'h0040_0000),
					rand_period(), lo, hi);
			// one phase runs flat out on both channels
			tx_idle_on = (phase != 3);
			rx_idle_on = (phase != 3);
			meas       = mir_target;
			repeat (50) begin
				meas = rand_sample(meas);
				send_sample(meas);
			end
			drain_actions();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : run_tests
		arst_n = 1'b0;
		sample_ch.valid    <= 1'b0;
		sample_ch.measured <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_field_extremes();
		test_zero_period();
		test_crossed_limits();
		test_gain_change();
		test_spare_register();
		test_backpressure();
		test_random_phases();

		// let any stray action show itself
		repeat (100) @(posedge clk);
		if (drive_expected.size() != 0) begin
			$error("drive: %0d expected values never arrived", drive_expected.size());
			err_count++;
		end
		$display("%0d samples sent, %0d actions checked", samples_sent, drives_checked);
		$display("%0d register writes over %0d settings, incl. crossed limits, zero period",
			reg_writes, settings_used);
		if (err_count == 0)
			$display("pid_controller_with_clamp_core_tb: done, clean");
		else
			$display("pid_controller_with_clamp_core_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#(10_000_000);
		$display("pid_controller_with_clamp_core_tb: done, errors");
		$finish;
	end

endmodule
